// ----- design/guroll_pkg.sv -----
`timescale 1ns / 1ps
package guroll_pkg;

  // width of the unnormalized up vector and of the vectoring datapath
  localparam int GW = 34;

  typedef enum logic [1:0] {
    FAIL_NONE  = 2'd0,
    FAIL_LEN   = 2'd1,
    FAIL_DEGEN = 2'd2
  } fail_t;

  // control that travels with each item down the chain
  typedef struct packed {
    logic  valid;
    fail_t fail;
  } ctl_t;

  // shift-subtract division, elaboration only
  function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], a[k]};
      if (r >= b) begin
        r = r - b;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/m) in Q60 by series
  function automatic longint atan_inv_q60(longint unsigned m);
    longint unsigned p;
    longint unsigned mm;
    longint unsigned k;
    longint acc;
    longint term;
    p = udiv(64'd1 << 60, m);
    mm = m * m;
    acc = 64'sd0;
    k = 64'd0;
    while (p != 64'd0) begin
      term = longint'(udiv(p, 2 * k + 1));
      acc = k[0] ? acc - term : acc + term;
      p = udiv(p, mm);
      k = k + 1;
    end
    return acc;
  endfunction

  function automatic longint q60_to_fx(longint v, int f);
    return (v + (64'sd1 <<< (59 - f))) >>> (60 - f);
  endfunction

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned res;
    longint unsigned bits;
    longint unsigned rem;
    res = 64'd0;
    rem = v;
    bits = 64'd1 << 62;
    while (bits > rem) bits = bits >> 2;
    while (bits != 64'd0) begin
      if (rem >= res + bits) begin
        rem = rem - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  function automatic longint quarter_pi_q60();
    return 4 * atan_inv_q60(64'd5) - atan_inv_q60(64'd239);
  endfunction

  function automatic longint pi_fx(int f);
    return q60_to_fx(4 * quarter_pi_q60(), f);
  endfunction

  function automatic longint atan_fx(int i, int f);
    if (i == 0) return q60_to_fx(quarter_pi_q60(), f);
    return q60_to_fx(atan_inv_q60(64'd1 << i), f);
  endfunction

  // inverse CORDIC gain over the given number of stages
  function automatic longint gain_fx(int stages, int f);
    longint unsigned k2;
    longint k30;
    k2 = 64'd1 << 60;
    for (int i = 0; i < stages; i++) begin
      k2 = k2 - udiv(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    k30 = longint'(isqrt64(k2));
    if (f >= 30) return k30;
    return (k30 + (64'sd1 <<< (29 - f))) >>> (30 - f);
  endfunction

endpackage

// ----- design/gravity_upright_roll_quaternion.sv -----
`timescale 1ns / 1ps
// Roll quaternion from a head orientation quaternion.
// Input channel: in_valid / in_stall carry one item, the head quaternion
// in_head_x/y/z/w in signed Q2.14. Result channel: out_valid / out_stall
// carry out_valid_res, out_fail_reason (0 ok, 1 length out of range,
// 2 up vector degenerate) and the roll quaternion z/w terms in Q2.14.
// A failed item reports zeros in out_roll_z and out_roll_w.
// Throughput: one item per cycle while in_stall is low. Each item runs a pipeline:
// six front stages (products, length check, degenerate test, quadrant
// fold), CORDIC_STAGES vectoring cells, CORDIC_STAGES rotation cells and
// the output register.
// Reset clears every valid bit; no item is in flight afterward.
// When the receiver stalls, the held result stays on the output and one
// more result is caught in a skid register; only once that register is
// full does in_stall rise and the whole pipeline freeze until the
// receiver takes the held result.
module gravity_upright_roll_quaternion #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_head_x,
  input  logic signed [15:0] in_head_y,
  input  logic signed [15:0] in_head_z,
  input  logic signed [15:0] in_head_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_valid_res,
  output logic [1:0]         out_fail_reason,
  output logic signed [15:0] out_roll_z,
  output logic signed [15:0] out_roll_w
);

  localparam int GW = guroll_pkg::GW;
  localparam int AW = FRAC_BITS + 4;
  localparam int CW = FRAC_BITS + 3;
  localparam int QW = CW + 4;
  localparam int SH_DN = (FRAC_BITS > 14) ? FRAC_BITS - 14 : 0;
  localparam int SH_UP = (FRAC_BITS > 14) ? 0 : 14 - FRAC_BITS;
  localparam logic signed [QW-1:0] RND =
    (FRAC_BITS > 14) ? (QW'(1) <<< (FRAC_BITS - 15)) : '0;
  localparam logic signed [CW-1:0] GAIN =
    CW'(guroll_pkg::gain_fx(CORDIC_STAGES, FRAC_BITS));

  logic en;
  logic s_full_r;
  logic o_valid_r;

  guroll_pkg::ctl_t     vctl [CORDIC_STAGES+1];
  logic signed [GW-1:0] vx   [CORDIC_STAGES+1];
  logic signed [GW-1:0] vy   [CORDIC_STAGES+1];
  logic signed [AW-1:0] va   [CORDIC_STAGES+1];

  guroll_pkg::ctl_t     rctl [CORDIC_STAGES+1];
  logic signed [CW-1:0] cx   [CORDIC_STAGES+1];
  logic signed [CW-1:0] cy   [CORDIC_STAGES+1];
  logic signed [AW-1:0] rh   [CORDIC_STAGES+1];

  assign en = !s_full_r;
  assign in_stall = s_full_r;

  guroll_front #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
    .hx(in_head_x), .hy(in_head_y), .hz(in_head_z), .hw(in_head_w),
    .ctl_o(vctl[0]), .vx_o(vx[0]), .vy_o(vy[0]), .ang_o(va[0])
  );

  // vectoring chain: roll angle
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    guroll_vec_cell #(.I(i), .FRAC_BITS(FRAC_BITS), .AW(AW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_i(vctl[i]), .vx_i(vx[i]), .vy_i(vy[i]), .ang_i(va[i]),
      .ctl_o(vctl[i+1]), .vx_o(vx[i+1]), .vy_o(vy[i+1]), .ang_o(va[i+1])
    );
  end

  // rotation chain starts from the gain-corrected unit vector, half angle
  assign rctl[0] = vctl[CORDIC_STAGES];
  assign cx[0]   = GAIN;
  assign cy[0]   = '0;
  assign rh[0]   = va[CORDIC_STAGES] >>> 1;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    guroll_rot_cell #(.I(i), .FRAC_BITS(FRAC_BITS), .AW(AW), .CW(CW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_i(rctl[i]), .cx_i(cx[i]), .cy_i(cy[i]), .half_i(rh[i]),
      .ctl_o(rctl[i+1]), .cx_o(cx[i+1]), .cy_o(cy[i+1]), .half_o(rh[i+1])
    );
  end

  // round to Q14, clamp, zero on failure
  logic signed [QW-1:0] qz, qw;
  logic signed [15:0] fz, fw;
  logic fok;
  guroll_pkg::ctl_t fctl;

  always_comb begin
    fctl = rctl[CORDIC_STAGES];
    fok  = (fctl.fail == guroll_pkg::FAIL_NONE);
    qz = ((QW'(cy[CORDIC_STAGES]) + RND) >>> SH_DN) <<< SH_UP;
    qw = ((QW'(cx[CORDIC_STAGES]) + RND) >>> SH_DN) <<< SH_UP;
    if (qz > QW'(16384)) fz = 16'sd16384;
    else if (qz < -QW'(16384)) fz = -16'sd16384;
    else fz = qz[15:0];
    if (qw > QW'(16384)) fw = 16'sd16384;
    else if (qw < -QW'(16384)) fw = -16'sd16384;
    else fw = qw[15:0];
    if (!fok) begin
      fz = '0;
      fw = '0;
    end
  end

  // output register plus skid register
  logic        o_res_r, s_res_r;
  logic [1:0]  o_fail_r, s_fail_r;
  logic signed [15:0] o_z_r, o_w_r, s_z_r, s_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      s_full_r  <= 1'b0;
    end else if (s_full_r) begin
      if (!out_stall) s_full_r <= 1'b0;
    end else if (!o_valid_r || !out_stall) begin
      o_valid_r <= fctl.valid;
    end else if (fctl.valid) begin
      s_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_full_r) begin
      if (!out_stall) begin
        o_res_r  <= s_res_r;
        o_fail_r <= s_fail_r;
        o_z_r    <= s_z_r;
        o_w_r    <= s_w_r;
      end
    end else if (!o_valid_r || !out_stall) begin
      o_res_r  <= fok;
      o_fail_r <= fctl.fail;
      o_z_r    <= fz;
      o_w_r    <= fw;
    end else begin
      s_res_r  <= fok;
      s_fail_r <= fctl.fail;
      s_z_r    <= fz;
      s_w_r    <= fw;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_valid_res   = o_res_r;
  assign out_fail_reason = o_fail_r;
  assign out_roll_z      = o_z_r;
  assign out_roll_w      = o_w_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    s_full_r |-> o_valid_r) else $error("skid holds an item with no output item");
  a_res_matches_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_res == (out_fail_reason == guroll_pkg::FAIL_NONE)))
    else $error("valid_res disagrees with fail_reason");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_roll_z == 16'sd0 && out_roll_w == 16'sd0))
    else $error("failed item carries nonzero roll");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_z <= 16'sd16384 && out_roll_z >= -16'sd16384 &&
                   out_roll_w <= 16'sd16384 && out_roll_w >= -16'sd16384))
    else $error("roll term out of range");
`endif

endmodule

// ----- design/guroll_front.sv -----
`timescale 1ns / 1ps
module guroll_front #(
  parameter int FRAC_BITS = 14,
  parameter int AW        = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [15:0]                hx,
  input  logic signed [15:0]                hy,
  input  logic signed [15:0]                hz,
  input  logic signed [15:0]                hw,
  output guroll_pkg::ctl_t                  ctl_o,
  output logic signed [guroll_pkg::GW-1:0]  vx_o,
  output logic signed [guroll_pkg::GW-1:0]  vy_o,
  output logic signed [AW-1:0]              ang_o
);

  localparam int GW = guroll_pkg::GW;
  localparam logic signed [AW-1:0] PI = AW'(guroll_pkg::pi_fx(FRAC_BITS));

  logic [4:0] v_r;

  // stage 1: products
  logic signed [31:0] xy_r, zw_r, xx_r, yy_r, zz_r, ww_r;
  // stage 2: length and up vector
  logic signed [34:0] n35;
  logic signed [GW-1:0] gx2, gy2;
  logic [29:0] n_r;
  logic signed [GW-1:0] gx_r, gy_r;
  logic bad_r;
  // stage 3: squares
  logic signed [21:0] gx22, gy22;
  logic [43:0] sqx_r, sqy_r;
  logic [59:0] nn_r;
  logic far_r, bad3_r;
  logic signed [GW-1:0] gx3_r, gy3_r;
  // stage 4: sum of squares
  logic [44:0] s45;
  logic [40:0] s_r;
  logic near_r, bad4_r;
  logic [59:0] nn4_r;
  logic signed [GW-1:0] gx4_r, gy4_r;
  // stage 5: scaled sum
  logic [60:0] p_r;
  logic near5_r, bad5_r;
  logic [59:0] nn5_r;
  logic signed [GW-1:0] gx5_r, gy5_r;
  // stage 6
  logic degen;
  guroll_pkg::fail_t fail6;
  logic signed [GW-1:0] vx6, vy6;
  logic signed [AW-1:0] base6;

  always_comb begin
    n35 = 35'(xx_r) + 35'(yy_r) + 35'(zz_r) + 35'(ww_r);
    gx2 = (GW'(xy_r) + GW'(zw_r)) <<< 1;
    gy2 = GW'(ww_r) + GW'(yy_r) - GW'(xx_r) - GW'(zz_r);
    gx22 = gx_r[21:0];
    gy22 = gy_r[21:0];
    s45 = {1'b0, sqx_r} + {1'b0, sqy_r};
    degen = near5_r && (p_r < 61'(nn5_r));
    if (bad5_r) fail6 = guroll_pkg::FAIL_LEN;
    else if (degen) fail6 = guroll_pkg::FAIL_DEGEN;
    else fail6 = guroll_pkg::FAIL_NONE;
    // pre-rotate by pi when the vector points into the left half plane
    if (gy5_r < 0) begin
      vx6 = -gy5_r;
      vy6 = gx5_r;
      base6 = (gx5_r <= 0) ? PI : -PI;
    end else begin
      vx6 = gy5_r;
      vy6 = -gx5_r;
      base6 = '0;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      ctl_o.valid <= 1'b0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_vld};
      ctl_o.valid <= v_r[4];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      xy_r <= hx * hy;
      zw_r <= hz * hw;
      xx_r <= hx * hx;
      yy_r <= hy * hy;
      zz_r <= hz * hz;
      ww_r <= hw * hw;

      n_r   <= n35[29:0];
      gx_r  <= gx2;
      gy_r  <= gy2;
      bad_r <= (n35 < 35'sd67108864) || (n35 > 35'sd603979776);

      sqx_r  <= $unsigned(44'(gx22 * gx22));
      sqy_r  <= $unsigned(44'(gy22 * gy22));
      nn_r   <= 60'(n_r) * 60'(n_r);
      far_r  <= (gx_r >= 34'sd2097152) || (gx_r <= -34'sd2097152) ||
                (gy_r >= 34'sd2097152) || (gy_r <= -34'sd2097152);
      bad3_r <= bad_r;
      gx3_r  <= gx_r;
      gy3_r  <= gy_r;

      s_r    <= s45[40:0];
      near_r <= !far_r && (s45 < 45'd2199023255552);
      bad4_r <= bad3_r;
      nn4_r  <= nn_r;
      gx4_r  <= gx3_r;
      gy4_r  <= gy3_r;

      p_r     <= 61'(s_r) * 61'd1000000;
      near5_r <= near_r;
      bad5_r  <= bad4_r;
      nn5_r   <= nn4_r;
      gx5_r   <= gx4_r;
      gy5_r   <= gy4_r;

      ctl_o.fail <= fail6;
      vx_o  <= vx6;
      vy_o  <= vy6;
      ang_o <= base6;
    end
  end

endmodule

// ----- design/guroll_vec_cell.sv -----
`timescale 1ns / 1ps
module guroll_vec_cell #(
  parameter int I         = 0,
  parameter int FRAC_BITS = 14,
  parameter int AW        = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  guroll_pkg::ctl_t                  ctl_i,
  input  logic signed [guroll_pkg::GW-1:0]  vx_i,
  input  logic signed [guroll_pkg::GW-1:0]  vy_i,
  input  logic signed [AW-1:0]              ang_i,
  output guroll_pkg::ctl_t                  ctl_o,
  output logic signed [guroll_pkg::GW-1:0]  vx_o,
  output logic signed [guroll_pkg::GW-1:0]  vy_o,
  output logic signed [AW-1:0]              ang_o
);

  localparam logic signed [AW-1:0] ATAN = AW'(guroll_pkg::atan_fx(I, FRAC_BITS));

  logic signed [guroll_pkg::GW-1:0] nx, ny;
  logic signed [AW-1:0] na;

  // one vectoring micro-rotation: drive vy toward zero
  always_comb begin
    if (vy_i > 0) begin
      nx = vx_i + (vy_i >>> I);
      ny = vy_i - (vx_i >>> I);
      na = ang_i + ATAN;
    end else begin
      nx = vx_i - (vy_i >>> I);
      ny = vy_i + (vx_i >>> I);
      na = ang_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.valid <= 1'b0;
    end else if (en) begin
      ctl_o.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o.fail <= ctl_i.fail;
      vx_o  <= nx;
      vy_o  <= ny;
      ang_o <= na;
    end
  end

endmodule

// ----- design/guroll_rot_cell.sv -----
`timescale 1ns / 1ps
module guroll_rot_cell #(
  parameter int I         = 0,
  parameter int FRAC_BITS = 14,
  parameter int AW        = 18,
  parameter int CW        = 17
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  guroll_pkg::ctl_t      ctl_i,
  input  logic signed [CW-1:0]  cx_i,
  input  logic signed [CW-1:0]  cy_i,
  input  logic signed [AW-1:0]  half_i,
  output guroll_pkg::ctl_t      ctl_o,
  output logic signed [CW-1:0]  cx_o,
  output logic signed [CW-1:0]  cy_o,
  output logic signed [AW-1:0]  half_o
);

  localparam logic signed [AW-1:0] ATAN = AW'(guroll_pkg::atan_fx(I, FRAC_BITS));

  logic signed [CW-1:0] nx, ny;
  logic signed [AW-1:0] nh;

  // one rotation micro-step: drive the residual angle toward zero
  always_comb begin
    if (half_i >= 0) begin
      nx = cx_i - (cy_i >>> I);
      ny = cy_i + (cx_i >>> I);
      nh = half_i - ATAN;
    end else begin
      nx = cx_i + (cy_i >>> I);
      ny = cy_i - (cx_i >>> I);
      nh = half_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.valid <= 1'b0;
    end else if (en) begin
      ctl_o.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o.fail <= ctl_i.fail;
      cx_o   <= nx;
      cy_o   <= ny;
      half_o <= nh;
    end
  end

endmodule
